[hw/rtl/tmlk_pkg.sv]
// ----------------------------------------------------------------------------
// tmlk_pkg
// Shared widths, register codes, reset values and types for the trimmed-mean
// ladder key decoder.
// ----------------------------------------------------------------------------
package tmlk_pkg;

  localparam int WINDOW     = 10;
  localparam int NUM_KEYS   = 6;
  localparam int NUM_LEVELS = 6;

  localparam int SAMPLE_W = 12;
  localparam int SUPPLY_W = 12;
  localparam int LEVEL_W  = 10;
  localparam int SUM_W    = 16;
  localparam int CNT_W    = 4;
  localparam int INDEX_W  = 3;
  localparam int PROD_W   = 22;

  localparam int DIVISOR  = (WINDOW > 2) ? (WINDOW - 2) : 1;
  localparam int PERMILLE = 1000;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [2:0] REG_SUPPLY  = 3'd0;
  localparam logic [2:0] REG_LEVEL_1 = 3'd1;
  localparam logic [2:0] REG_LEVEL_2 = 3'd2;
  localparam logic [2:0] REG_LEVEL_3 = 3'd3;
  localparam logic [2:0] REG_LEVEL_4 = 3'd4;
  localparam logic [2:0] REG_LEVEL_5 = 3'd5;
  localparam logic [2:0] REG_LEVEL_6 = 3'd6;

  localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = SUPPLY_W'(3106);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET [NUM_LEVELS] = '{
    LEVEL_W'(220), LEVEL_W'(384), LEVEL_W'(525),
    LEVEL_W'(673), LEVEL_W'(830), LEVEL_W'(990)
  };

  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] mean;
  } win_res_t;

endpackage

[hw/rtl/trimmed_mean_ladder_key_decode_unit.sv]
// ----------------------------------------------------------------------------
// trimmed_mean_ladder_key_decode_unit
// Windowed trimmed-mean filter and resistor-ladder key band decoder.
// ----------------------------------------------------------------------------
// Takes one sample request per cycle while in_ready is high. Each sample
// updates the window count, sum, minimum and maximum; every WINDOW-th sample
// closes the window and produces one result (trimmed mean, key found flag
// and key index), passing the sample register, the mean register and the
// result register in turn. A result waiting at the output stalls the input
// only once the mean register also holds a result and yet another window
// closes behind them. Register writes take effect for samples accepted
// from the next cycle on; the band products are registered from the new
// values in the cycle after a write.
module trimmed_mean_ladder_key_decode_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tmlk_pkg::SAMPLE_W-1:0]   in_sample_mv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tmlk_pkg::SAMPLE_W-1:0]   out_mean_mv,
  output logic                            out_key_found,
  output logic [tmlk_pkg::INDEX_W-1:0]    out_key_index,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tmlk_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [tmlk_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [tmlk_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import tmlk_pkg::*;

  prod_t    prod [NUM_LEVELS];
  win_res_t res;
  logic     res_ready;

  tmlk_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .prod        (prod)
  );

  tmlk_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_mv (in_sample_mv),
    .res          (res),
    .res_ready    (res_ready)
  );

  tmlk_match u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_ready     (res_ready),
    .prod          (prod),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mean_mv   (out_mean_mv),
    .out_key_found (out_key_found),
    .out_key_index (out_key_index)
  );

endmodule

[hw/rtl/tmlk_cfg.sv]
// ----------------------------------------------------------------------------
// tmlk_cfg
// APB register file for supply and ladder levels; keeps the per-band
// level*supply products registered for the key matcher.
// ----------------------------------------------------------------------------
module tmlk_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tmlk_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [tmlk_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [tmlk_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output tmlk_pkg::prod_t                  prod [tmlk_pkg::NUM_LEVELS]
);
  import tmlk_pkg::*;

  logic [SUPPLY_W-1:0] supply_r;
  logic [LEVEL_W-1:0]  level_r [NUM_LEVELS];
  prod_t               prod_r  [NUM_LEVELS];
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        level_r[k] <= LEVEL_RESET[k];
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_SUPPLY:  supply_r   <= cfg_pwdata[SUPPLY_W-1:0];
        REG_LEVEL_1: level_r[0] <= cfg_pwdata[LEVEL_W-1:0];
        REG_LEVEL_2: level_r[1] <= cfg_pwdata[LEVEL_W-1:0];
        REG_LEVEL_3: level_r[2] <= cfg_pwdata[LEVEL_W-1:0];
        REG_LEVEL_4: level_r[3] <= cfg_pwdata[LEVEL_W-1:0];
        REG_LEVEL_5: level_r[4] <= cfg_pwdata[LEVEL_W-1:0];
        REG_LEVEL_6: level_r[5] <= cfg_pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        prod_r[k] <= PROD_W'(LEVEL_RESET[k]) * PROD_W'(SUPPLY_RESET);
      end
    end else begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        prod_r[k] <= PROD_W'(level_r[k]) * PROD_W'(supply_r);
      end
    end
  end

  assign prod = prod_r;

  always_comb begin
    case (reg_idx)
      REG_SUPPLY:  cfg_prdata = APB_DATA_W'(supply_r);
      REG_LEVEL_1: cfg_prdata = APB_DATA_W'(level_r[0]);
      REG_LEVEL_2: cfg_prdata = APB_DATA_W'(level_r[1]);
      REG_LEVEL_3: cfg_prdata = APB_DATA_W'(level_r[2]);
      REG_LEVEL_4: cfg_prdata = APB_DATA_W'(level_r[3]);
      REG_LEVEL_5: cfg_prdata = APB_DATA_W'(level_r[4]);
      REG_LEVEL_6: cfg_prdata = APB_DATA_W'(level_r[5]);
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

[hw/rtl/tmlk_window.sv]
// ----------------------------------------------------------------------------
// tmlk_window
// Sample register, window count/sum/min/max, and trimmed-mean register
// loaded on the last sample of each window.
// ----------------------------------------------------------------------------
module tmlk_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tmlk_pkg::SAMPLE_W-1:0] in_sample_mv,
  output tmlk_pkg::win_res_t            res,
  input  logic                          res_ready
);
  import tmlk_pkg::*;

  logic                a_valid_r;
  logic [SAMPLE_W-1:0] a_sample_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;
  logic                b_valid_r;
  logic [SAMPLE_W-1:0] b_mean_r;

  logic [CNT_W-1:0]    cnt_nxt;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SAMPLE_W-1:0] min_nxt;
  logic [SAMPLE_W-1:0] max_nxt;
  logic [SAMPLE_W:0]   ends_sum;
  logic [SUM_W-1:0]    trimmed;
  logic [SUM_W-1:0]    quot;
  logic [SAMPLE_W-1:0] mean_nxt;
  logic                done;
  logic                b_free;
  logic                a_go;

  always_comb begin
    sum_nxt  = sum_r + SUM_W'(a_sample_r);
    min_nxt  = (a_sample_r < min_r) ? a_sample_r : min_r;
    max_nxt  = (a_sample_r > max_r) ? a_sample_r : max_r;
    cnt_nxt  = cnt_r + CNT_W'(1);
    done     = !(({1'b0, cnt_nxt} < (CNT_W + 1)'(WINDOW)) && (cnt_nxt != '0));
    ends_sum = {1'b0, min_nxt} + {1'b0, max_nxt};
    if ((SUM_W + 1)'(ends_sum) > (SUM_W + 1)'(sum_nxt)) begin
      trimmed = '0;
    end else begin
      trimmed = sum_nxt - SUM_W'(ends_sum);
    end
    quot     = trimmed / SUM_W'(DIVISOR);
    mean_nxt = (quot > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
  end

  assign b_free   = !b_valid_r | res_ready;
  assign a_go     = a_valid_r & (!done | b_free);
  assign in_ready = !a_valid_r | a_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_sample_r <= in_sample_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= SAMPLE_MAX;
      max_r <= '0;
    end else if (a_go) begin
      if (done) begin
        cnt_r <= '0;
        sum_r <= '0;
        min_r <= SAMPLE_MAX;
        max_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_go & done;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_go && done) begin
      b_mean_r <= mean_nxt;
    end
  end

  assign res.valid = b_valid_r;
  assign res.mean  = b_mean_r;

endmodule

[hw/rtl/tmlk_match.sv]
// ----------------------------------------------------------------------------
// tmlk_match
// Band search of the trimmed mean against the scaled ladder levels, and the
// result register.
// ----------------------------------------------------------------------------
module tmlk_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmlk_pkg::win_res_t            res,
  output logic                          res_ready,
  input  tmlk_pkg::prod_t               prod [tmlk_pkg::NUM_LEVELS],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmlk_pkg::SAMPLE_W-1:0] out_mean_mv,
  output logic                          out_key_found,
  output logic [tmlk_pkg::INDEX_W-1:0]  out_key_index
);
  import tmlk_pkg::*;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic                found_r;
  logic [INDEX_W-1:0]  index_r;

  prod_t               scaled;
  prod_t               lo;
  logic                found_nxt;
  logic [INDEX_W-1:0]  index_nxt;

  // mean <= level*supply/1000 exactly when 1000*mean <= level*supply
  always_comb begin
    scaled    = prod_t'(res.mean) * prod_t'(PERMILLE);
    found_nxt = 1'b0;
    index_nxt = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      lo = (i == 0) ? '0 : prod[(i == 0) ? 0 : i - 1];
      if ((lo < scaled) && (scaled <= prod[i])) begin
        found_nxt = 1'b1;
        index_nxt = INDEX_W'(i);
      end
    end
  end

  assign res_ready = !out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      mean_r  <= res.mean;
      found_r <= found_nxt;
      index_r <= index_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mean_mv   = mean_r;
  assign out_key_found = found_r;
  assign out_key_index = index_r;

endmodule
